@@ design/nbacc_pkg.sv @@
// Shared types, constants and saturating arithmetic for the force and jerk accumulator.
package nbacc_pkg;

    localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SMIN = 64'h8000_0000_0000_0000;
    localparam logic [63:0] UMAX = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] TRIPLE = 64'd3;

    // Two's complement shift codes for the multiplier.
    localparam logic [7:0] SH_NONE = 8'h00;
    localparam logic [7:0] SH_DN32 = 8'hE0;
    localparam logic [7:0] SH_DN40 = 8'hD8;
    localparam logic [7:0] E2_BIAS = 8'd54;
    localparam logic [7:0] E3_BIAS = 8'd65;

    localparam int QUEUE_DEPTH_DEF = 2;

    typedef enum logic [1:0] {
        KIND_LOAD,
        KIND_SRC,
        KIND_SKIP
    } kind_t;

    typedef struct packed {
        kind_t            kind;
        logic             last;
        logic [2:0][63:0] pos;
        logic [2:0][63:0] vel;
        logic [31:0]      mass;
    } cmd_t;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
        logic        b_signed;
        logic [7:0]  shift;
    } mul_req_t;

    typedef struct packed {
        logic         done;
        logic [63:0]  res;
        logic [127:0] prod;
    } mul_rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_SOFT,
        S_NORM,
        S_SQRT,
        S_DIV,
        S_EMIT
    } state_t;

    typedef enum logic [3:0] {
        OP_SQ,
        OP_RV,
        OP_I2,
        OP_I3,
        OP_MR3,
        OP_AL,
        OP_AL3,
        OP_C,
        OP_ACC,
        OP_JRK
    } op_t;

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        if (((a ^ s) & (b ^ s)) >> 63 != 64'd0)
            return a[63] ? SMIN : SMAX;
        return s;
    endfunction

    function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a - b;
        if (((a ^ b) & (a ^ s)) >> 63 != 64'd0)
            return a[63] ? SMIN : SMAX;
        return s;
    endfunction

    function automatic logic [63:0] uadd_sat(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? UMAX : s[63:0];
    endfunction

    // Scale a magnitude product by 2^shift, then saturate and apply the sign.
    function automatic logic [63:0] mul_fin(input logic [127:0] prod, input logic neg,
                                            input logic [7:0] shift);
        logic [127:0] p;
        logic [63:0]  lo;
        logic [63:0]  lim;
        logic         sat;
        logic [7:0]   s;
        sat = 1'b0;
        lim = neg ? SMIN : SMAX;
        p = prod;
        s = 8'd0;
        if (shift[7])
        begin
            s = 8'd0 - shift;
            p = prod >> s;
        end
        else if (shift != 8'd0 && prod != 128'd0)
        begin
            if (shift >= 8'd64)
                sat = 1'b1;
            else if ((prod >> (8'd64 - shift)) != 128'd0)
                sat = 1'b1;
            p = prod << shift;
        end
        if (p[127:64] != 64'd0)
            sat = 1'b1;
        lo = p[63:0];
        if (sat || lo > lim)
            lo = lim;
        return neg ? 64'd0 - lo : lo;
    endfunction

endpackage

@@ design/nbacc_front.sv @@
// Input side: accepts words, tracks the target index and classifies each item.
module nbacc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [431:0]        s_tdata,
    input  logic                s_tuser,
    input  logic                s_tlast,
    output logic                q_wr_en,
    output nbacc_pkg::cmd_t     q_wr_data,
    input  logic                q_full
);
    import nbacc_pkg::*;

    logic [15:0] tgt_idx_reg;
    logic [15:0] tgt_idx_next;
    logic [15:0] idx;
    logic        accept;

    assign s_tready = !q_full;
    assign accept = s_tvalid && s_tready;
    assign idx = s_tdata[15:0];
    assign q_wr_en = accept;

    always_comb
    begin
        tgt_idx_next = tgt_idx_reg;
        q_wr_data.last = s_tlast;
        q_wr_data.pos[0] = s_tdata[79:16];
        q_wr_data.pos[1] = s_tdata[143:80];
        q_wr_data.pos[2] = s_tdata[207:144];
        q_wr_data.vel[0] = s_tdata[271:208];
        q_wr_data.vel[1] = s_tdata[335:272];
        q_wr_data.vel[2] = s_tdata[399:336];
        q_wr_data.mass = s_tdata[431:400];
        if (!s_tuser)
        begin
            q_wr_data.kind = KIND_LOAD;
            if (accept)
                tgt_idx_next = idx;
        end
        else if (idx == tgt_idx_reg)
            q_wr_data.kind = KIND_SKIP;
        else
            q_wr_data.kind = KIND_SRC;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tgt_idx_reg <= 16'd0;
        else
            tgt_idx_reg <= tgt_idx_next;
    end

endmodule

@@ design/nbacc_fifo.sv @@
// Short command queue between the input side and the arithmetic engine.
module nbacc_fifo #(
    parameter int DEPTH = nbacc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  nbacc_pkg::cmd_t wr_data,
    output logic            full,
    input  logic            rd_en,
    output nbacc_pkg::cmd_t rd_data,
    output logic            empty
);
    import nbacc_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_wr;
    logic          do_rd;

    assign full = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_wr && !do_rd)
                count_reg <= count_reg + 1'b1;
            else if (do_rd && !do_wr)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

@@ design/nbacc_mul.sv @@
// Shared 64x64 multiplier: four 32x32 partial products, then scaling and saturation.
module nbacc_mul (
    input  logic                clk,
    input  logic                rst_n,
    input  nbacc_pkg::mul_req_t req,
    output nbacc_pkg::mul_rsp_t rsp
);
    import nbacc_pkg::*;

    logic [63:0]  am_reg;
    logic [63:0]  bm_reg;
    logic         neg_reg;
    logic [7:0]   sh_reg;
    logic [127:0] acc_reg;
    logic [2:0]   step_reg;
    logic         run_reg;
    logic         done_reg;
    logic [63:0]  res_reg;
    logic         bn;
    logic [63:0]  pp;
    logic [127:0] pp_sh;

    assign bn = req.b_signed && req.b[63];

    always_comb
    begin
        case (step_reg[1:0])
            2'd0: pp = am_reg[31:0] * bm_reg[31:0];
            2'd1: pp = am_reg[31:0] * bm_reg[63:32];
            2'd2: pp = am_reg[63:32] * bm_reg[31:0];
            default: pp = am_reg[63:32] * bm_reg[63:32];
        endcase
        case (step_reg[1:0])
            2'd0: pp_sh = {64'd0, pp};
            2'd3: pp_sh = {pp, 64'd0};
            default: pp_sh = {32'd0, pp, 32'd0};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 3'd0;
            am_reg <= 64'd0;
            bm_reg <= 64'd0;
            neg_reg <= 1'b0;
            sh_reg <= 8'd0;
            acc_reg <= 128'd0;
            res_reg <= 64'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                am_reg <= req.a[63] ? 64'd0 - req.a : req.a;
                bm_reg <= bn ? 64'd0 - req.b : req.b;
                neg_reg <= req.a[63] ^ bn;
                sh_reg <= req.shift;
                acc_reg <= 128'd0;
                step_reg <= 3'd0;
                run_reg <= 1'b1;
            end
            else if (run_reg)
            begin
                if (step_reg[2])
                begin
                    res_reg <= mul_fin(acc_reg, neg_reg, sh_reg);
                    done_reg <= 1'b1;
                    run_reg <= 1'b0;
                end
                else
                begin
                    acc_reg <= acc_reg + pp_sh;
                    step_reg <= step_reg + 3'd1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.res = res_reg;
    assign rsp.prod = acc_reg;

endmodule

@@ design/nbacc_core.sv @@
// Arithmetic engine: target state, interaction sequencer, sums and result register.
module nbacc_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [63:0]     cfg_wdata,
    input  nbacc_pkg::cmd_t q_rd_data,
    input  logic            q_empty,
    output logic            q_rd_en,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [383:0]    m_tdata
);
    import nbacc_pkg::*;

    state_t           state_reg, state_next;
    op_t              op_reg, op_next;
    logic [1:0]       k_reg, k_next;
    logic [63:0]      soft_reg;
    logic [2:0][63:0] tpos_reg, tpos_next;
    logic [2:0][63:0] tvel_reg, tvel_next;
    logic [2:0][63:0] acc_reg, acc_next;
    logic [2:0][63:0] jerk_reg, jerk_next;
    logic [2:0][63:0] dp_reg, dp_next;
    logic [2:0][63:0] dv_reg, dv_next;
    logic [31:0]      mass_reg, mass_next;
    logic             last_reg, last_next;
    logic [63:0]      r2_reg, r2_next;
    logic [63:0]      rv_reg, rv_next;
    logic [63:0]      nrm_reg, nrm_next;
    logic [5:0]       sh_reg, sh_next;
    logic [63:0]      sx_reg, sx_next;
    logic [63:0]      sres_reg, sres_next;
    logic [63:0]      sbit_reg, sbit_next;
    logic [33:0]      rem_reg, rem_next;
    logic [63:0]      quo_reg, quo_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic [63:0]      inv_reg, inv_next;
    logic [63:0]      i2_reg, i2_next;
    logic [63:0]      tmp_reg, tmp_next;
    logic [63:0]      mr3_reg, mr3_next;
    logic [63:0]      c_reg, c_next;
    logic             out_valid_reg, out_valid_next;
    logic [383:0]     out_data_reg, out_data_next;

    mul_req_t    mreq;
    mul_rsp_t    mrsp;
    logic [7:0]  e2;
    logic [7:0]  e3;
    logic [7:0]  h3;
    logic [63:0] sq_term;
    logic [63:0] s_try;
    logic [33:0] rem_sh;
    logic [63:0] r2_soft;
    state_t      fin_state;

    nbacc_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .rsp   (mrsp)
    );

    // Scale exponents: 2h-62 and 3h-77 with h = sh/2 + 4.
    assign e2 = {2'b00, sh_reg} - E2_BIAS;
    assign h3 = {3'b000, sh_reg[5:1]} + {2'b00, sh_reg[5:1], 1'b0};
    assign e3 = h3 - E3_BIAS;
    assign sq_term = (mrsp.prod[127:104] != 24'd0) ? UMAX : mrsp.prod[103:40];
    assign s_try = sres_reg + sbit_reg;
    assign rem_sh = {rem_reg[32:0], (cnt_reg != 6'd63)};
    assign r2_soft = uadd_sat(r2_reg, soft_reg);
    assign fin_state = last_reg ? S_EMIT : S_IDLE;

    always_comb
    begin
        mreq.start = (state_reg == S_ISSUE);
        mreq.a = dp_reg[k_reg];
        mreq.b = dp_reg[k_reg];
        mreq.b_signed = 1'b1;
        mreq.shift = SH_NONE;
        case (op_reg)
            OP_SQ: ;
            OP_RV:
            begin
                mreq.b = dv_reg[k_reg];
                mreq.shift = SH_DN40;
            end
            OP_I2:
            begin
                mreq.a = inv_reg;
                mreq.b = inv_reg;
                mreq.b_signed = 1'b0;
                mreq.shift = SH_DN32;
            end
            OP_I3:
            begin
                mreq.a = i2_reg;
                mreq.b = inv_reg;
                mreq.b_signed = 1'b0;
                mreq.shift = SH_DN32;
            end
            OP_MR3:
            begin
                mreq.a = tmp_reg;
                mreq.b = {32'd0, mass_reg};
                mreq.b_signed = 1'b0;
                mreq.shift = SH_DN32;
            end
            OP_AL:
            begin
                mreq.a = rv_reg;
                mreq.b = i2_reg;
                mreq.b_signed = 1'b0;
                mreq.shift = e2;
            end
            OP_AL3:
            begin
                mreq.a = tmp_reg;
                mreq.b = TRIPLE;
                mreq.b_signed = 1'b0;
            end
            OP_C:
            begin
                mreq.a = tmp_reg;
                mreq.shift = SH_DN40;
            end
            OP_ACC:
            begin
                mreq.b = mr3_reg;
                mreq.b_signed = 1'b0;
                mreq.shift = e3;
            end
            OP_JRK:
            begin
                mreq.a = sat_sub(dv_reg[k_reg], c_reg);
                mreq.b = mr3_reg;
                mreq.b_signed = 1'b0;
                mreq.shift = e3;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg;
        k_next = k_reg;
        tpos_next = tpos_reg;
        tvel_next = tvel_reg;
        acc_next = acc_reg;
        jerk_next = jerk_reg;
        dp_next = dp_reg;
        dv_next = dv_reg;
        mass_next = mass_reg;
        last_next = last_reg;
        r2_next = r2_reg;
        rv_next = rv_reg;
        nrm_next = nrm_reg;
        sh_next = sh_reg;
        sx_next = sx_reg;
        sres_next = sres_reg;
        sbit_next = sbit_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        inv_next = inv_reg;
        i2_next = i2_reg;
        tmp_next = tmp_reg;
        mr3_next = mr3_reg;
        c_next = c_reg;
        out_valid_next = out_valid_reg;
        out_data_next = out_data_reg;
        q_rd_en = 1'b0;

        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_rd_en = 1'b1;
                    last_next = q_rd_data.last;
                    mass_next = q_rd_data.mass;
                    unique case (q_rd_data.kind)
                        KIND_LOAD:
                        begin
                            tpos_next = q_rd_data.pos;
                            tvel_next = q_rd_data.vel;
                            acc_next = '0;
                            jerk_next = '0;
                        end
                        KIND_SKIP:
                        begin
                            if (q_rd_data.last)
                                state_next = S_EMIT;
                        end
                        default:
                        begin
                            for (int k = 0; k < 3; k++)
                            begin
                                dp_next[k] = sat_sub(q_rd_data.pos[k], tpos_reg[k]);
                                dv_next[k] = sat_sub(q_rd_data.vel[k], tvel_reg[k]);
                            end
                            r2_next = 64'd0;
                            rv_next = 64'd0;
                            k_next = 2'd0;
                            op_next = OP_SQ;
                            state_next = S_ISSUE;
                        end
                    endcase
                end
            end
            S_ISSUE:
                state_next = S_WAIT;
            S_WAIT:
            begin
                if (mrsp.done)
                begin
                    state_next = S_ISSUE;
                    unique case (op_reg)
                        OP_SQ:
                        begin
                            r2_next = uadd_sat(r2_reg, sq_term);
                            op_next = OP_RV;
                        end
                        OP_RV:
                        begin
                            rv_next = sat_add(rv_reg, mrsp.res);
                            if (k_reg == 2'd2)
                                state_next = S_SOFT;
                            else
                            begin
                                k_next = k_reg + 2'd1;
                                op_next = OP_SQ;
                            end
                        end
                        OP_I2:
                        begin
                            i2_next = mrsp.res;
                            op_next = OP_I3;
                        end
                        OP_I3:
                        begin
                            tmp_next = mrsp.res;
                            op_next = OP_MR3;
                        end
                        OP_MR3:
                        begin
                            mr3_next = mrsp.res;
                            op_next = OP_AL;
                        end
                        OP_AL:
                        begin
                            tmp_next = mrsp.res;
                            op_next = OP_AL3;
                        end
                        OP_AL3:
                        begin
                            tmp_next = mrsp.res;
                            k_next = 2'd0;
                            op_next = OP_C;
                        end
                        OP_C:
                        begin
                            c_next = mrsp.res;
                            op_next = OP_ACC;
                        end
                        OP_ACC:
                        begin
                            acc_next[k_reg] = sat_add(acc_reg[k_reg], mrsp.res);
                            op_next = OP_JRK;
                        end
                        default:
                        begin
                            jerk_next[k_reg] = sat_add(jerk_reg[k_reg], mrsp.res);
                            if (k_reg == 2'd2)
                                state_next = fin_state;
                            else
                            begin
                                k_next = k_reg + 2'd1;
                                op_next = OP_C;
                            end
                        end
                    endcase
                end
            end
            S_SOFT:
            begin
                r2_next = r2_soft;
                if (r2_soft == 64'd0)
                    state_next = fin_state;
                else
                begin
                    nrm_next = r2_soft;
                    sh_next = 6'd0;
                    state_next = S_NORM;
                end
            end
            S_NORM:
            begin
                // Shift by two bits a cycle so the exponent stays even.
                if (nrm_reg[63:62] == 2'b00)
                begin
                    nrm_next = {nrm_reg[61:0], 2'b00};
                    sh_next = sh_reg + 6'd2;
                end
                else
                begin
                    sx_next = {nrm_reg[63:32], 32'd0};
                    sres_next = 64'd0;
                    sbit_next = 64'h4000_0000_0000_0000;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (sbit_reg != 64'd0)
                begin
                    if (sx_reg >= s_try)
                    begin
                        sx_next = sx_reg - s_try;
                        sres_next = (sres_reg >> 1) + sbit_reg;
                    end
                    else
                        sres_next = sres_reg >> 1;
                    sbit_next = sbit_reg >> 2;
                end
                else
                begin
                    rem_next = 34'd0;
                    quo_next = 64'd0;
                    cnt_next = 6'd63;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                // Restoring division of the largest signed value by the root.
                if (rem_sh >= {2'b00, sres_reg[31:0]})
                begin
                    rem_next = rem_sh - {2'b00, sres_reg[31:0]};
                    quo_next = {quo_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh;
                    quo_next = {quo_reg[62:0], 1'b0};
                end
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    inv_next = quo_next;
                    op_next = OP_I2;
                    state_next = S_ISSUE;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next = {jerk_reg[2], jerk_reg[1], jerk_reg[0],
                                     acc_reg[2], acc_reg[1], acc_reg[0]};
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg <= OP_SQ;
            k_reg <= 2'd0;
            soft_reg <= 64'd0;
            tpos_reg <= '0;
            tvel_reg <= '0;
            acc_reg <= '0;
            jerk_reg <= '0;
            dp_reg <= '0;
            dv_reg <= '0;
            mass_reg <= 32'd0;
            last_reg <= 1'b0;
            r2_reg <= 64'd0;
            rv_reg <= 64'd0;
            nrm_reg <= 64'd0;
            sh_reg <= 6'd0;
            sx_reg <= 64'd0;
            sres_reg <= 64'd0;
            sbit_reg <= 64'd0;
            rem_reg <= 34'd0;
            quo_reg <= 64'd0;
            cnt_reg <= 6'd0;
            inv_reg <= 64'd0;
            i2_reg <= 64'd0;
            tmp_reg <= 64'd0;
            mr3_reg <= 64'd0;
            c_reg <= 64'd0;
            out_valid_reg <= 1'b0;
            out_data_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg <= op_next;
            k_reg <= k_next;
            if (cfg_we)
                soft_reg <= cfg_wdata;
            tpos_reg <= tpos_next;
            tvel_reg <= tvel_next;
            acc_reg <= acc_next;
            jerk_reg <= jerk_next;
            dp_reg <= dp_next;
            dv_reg <= dv_next;
            mass_reg <= mass_next;
            last_reg <= last_next;
            r2_reg <= r2_next;
            rv_reg <= rv_next;
            nrm_reg <= nrm_next;
            sh_reg <= sh_next;
            sx_reg <= sx_next;
            sres_reg <= sres_next;
            sbit_reg <= sbit_next;
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            cnt_reg <= cnt_next;
            inv_reg <= inv_next;
            i2_reg <= i2_next;
            tmp_reg <= tmp_next;
            mr3_reg <= mr3_next;
            c_reg <= c_next;
            out_valid_reg <= out_valid_next;
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;

    a_norm_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SQRT |-> nrm_reg[63:62] != 2'b00)
        else $error("square root started on an unnormalized distance");

    a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> sres_reg[63:32] == 32'd0 && sres_reg[31])
        else $error("root outside the divisor range");

    a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT && out_valid_reg && !m_tready |=> state_reg == S_EMIT)
        else $error("result overwrote a word not yet taken");

    a_wait_mul: assert property (@(posedge clk) disable iff (!rst_n)
        mrsp.done |-> state_reg == S_WAIT)
        else $error("multiplier finished outside a wait");

endmodule

@@ design/nbody_acc_jerk_accumulator.sv @@
// Top level of the softened gravity acceleration and jerk accumulator.
//
//  Channel  Dir  Signals                            Contents
//  s_*      in   s_tvalid s_tready s_tdata s_tuser  one particle word, tlast ends a source run
//  m_*      out  m_tvalid m_tready m_tdata          summed acceleration and jerk
//  cfg_*    in   cfg_we cfg_wdata                   softening length squared
//
// A load is taken in S_IDLE alone, as is a skipped source that does not end a run; a skipped
// source that ends a run also passes through S_EMIT to emit a result. An accumulated source
// runs the normalize steps, the square root steps, 64 division steps and 20 passes through
// the shared multiplier; a zero softened distance ends it after the first six passes.
// Reset clears the target, the sums, the softening register and the queue at once.
// The input stalls only when the command queue is full; a waiting result stalls the
// engine only when the next result is ready.
module nbody_acc_jerk_accumulator #(
    parameter int QUEUE_DEPTH = nbacc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // particle_index, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, mass
    input  logic [431:0] s_tdata,
    // mode
    input  logic         s_tuser,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // acc_x, acc_y, acc_z, jerk_x, jerk_y, jerk_z
    output logic [383:0] m_tdata,
    input  logic         cfg_we,
    input  logic [63:0]  cfg_wdata
);
    import nbacc_pkg::*;

    cmd_t wr_cmd;
    cmd_t rd_cmd;
    logic q_wr_en;
    logic q_full;
    logic q_rd_en;
    logic q_empty;

    nbacc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .q_wr_en   (q_wr_en),
        .q_wr_data (wr_cmd),
        .q_full    (q_full)
    );

    nbacc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr_en),
        .wr_data (wr_cmd),
        .full    (q_full),
        .rd_en   (q_rd_en),
        .rd_data (rd_cmd),
        .empty   (q_empty)
    );

    nbacc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_rd_data (rd_cmd),
        .q_empty   (q_empty),
        .q_rd_en   (q_rd_en),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
